@@ src/epoch_seconds_to_calendar_core_assert.svh @@
// assertion macros shared by the epoch seconds to calendar rtl
// no dependencies; included by the modules that check their own logic
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define ESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is active
`define ESC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/esc_pkg.sv @@
// shared types, constants and the month table of the epoch to calendar block
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package esc_pkg;

  // calendar constants
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
  localparam logic [31:0] EPOCH_WEEKDAY = 32'd4;

  // epoch year residues for the leap rule
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  // reciprocals for exact division by constants: q = (n * recip) >> shift
  // days: (secs >> 7) / 675, 25 bit numerator
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam int          DAY_RECIP_SH  = 35;
  // hours: time of day / 3600, 17 bit numerator
  localparam logic [17:0] HOUR_RECIP    = 18'd149131;
  localparam int          HOUR_RECIP_SH = 29;
  // minutes: seconds of the hour / 60, 12 bit numerator
  localparam logic [12:0] MIN_RECIP     = 13'd4370;
  localparam int          MIN_RECIP_SH  = 18;
  // weeks: (days + 4) / 7, 16 bit numerator
  localparam logic [16:0] WDAY_RECIP    = 17'd74899;
  localparam int          WDAY_RECIP_SH = 19;

  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DAY_DIV,
    DP_DAY_SPLIT,
    DP_HOUR_DIV,
    DP_HOUR_SPLIT,
    DP_MIN_DIV,
    DP_MIN_SPLIT,
    DP_WDAY_DIV,
    DP_WDAY_SPLIT,
    DP_YEAR_STEP,
    DP_MONTH_STEP,
    DP_FINISH
  } dp_op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_DIV,
    ST_DAY_SPLIT,
    ST_HOUR_DIV,
    ST_HOUR_SPLIT,
    ST_MIN_DIV,
    ST_MIN_SPLIT,
    ST_WDAY_DIV,
    ST_WDAY_SPLIT,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } esc_cmd_t;

  typedef struct packed {
    logic year_fit;    // remaining days cover the whole current year
    logic month_more;  // remaining days reach the next month
    logic out_free;    // output register can take a result this cycle
  } esc_sts_t;

  // first day of month index m within the year
  function automatic logic [8:0] month_first(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && (m >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/epoch_seconds_to_calendar_core.sv @@
// from input accept to result valid the sequencer runs the divisions by constants, then
// one year step per year after 1970, one month step per month walked, a closing step for
// each walk and the write of the output register, which waits until that register is free
// the block converts one item at a time; the next item is taken once
// the result is in the output register, and a result waits there while the following
// item is converted; reset: rst_ni asynchronous active low, clears sequencer and output valid
`default_nettype none

module epoch_seconds_to_calendar_core
  import esc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] epoch_seconds
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [11:0] year, [15:12] month,
                                                 // [20:16] day_of_month, [25:21] hour,
                                                 // [31:26] minute, [37:32] second,
                                                 // [40:38] weekday, [47:41] zero
);

  esc_cmd_t cmd;
  esc_sts_t sts;

  // sequencer
  esc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and output register
  esc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .secs_i      (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ src/esc_ctrl.sv @@
// sequencer of the epoch to calendar block: divisions, year walk, month walk
// depends on esc_pkg; drives esc_dpath through command and status structs
`default_nettype none

module esc_ctrl
  import esc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  esc_sts_t sts_i,
  output esc_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_DAY_DIV;
      ST_DAY_DIV:    state_d = ST_DAY_SPLIT;
      ST_DAY_SPLIT:  state_d = ST_HOUR_DIV;
      ST_HOUR_DIV:   state_d = ST_HOUR_SPLIT;
      ST_HOUR_SPLIT: state_d = ST_MIN_DIV;
      ST_MIN_DIV:    state_d = ST_MIN_SPLIT;
      ST_MIN_SPLIT:  state_d = ST_WDAY_DIV;
      ST_WDAY_DIV:   state_d = ST_WDAY_SPLIT;
      ST_WDAY_SPLIT: state_d = ST_YEAR;
      ST_YEAR:       if (!sts_i.year_fit) state_d = ST_MONTH;
      ST_MONTH:      if (!sts_i.month_more) state_d = ST_DONE;
      ST_DONE:       if (sts_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = DP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_DAY_DIV:    cmd_o.op = DP_DAY_DIV;
      ST_DAY_SPLIT:  cmd_o.op = DP_DAY_SPLIT;
      ST_HOUR_DIV:   cmd_o.op = DP_HOUR_DIV;
      ST_HOUR_SPLIT: cmd_o.op = DP_HOUR_SPLIT;
      ST_MIN_DIV:    cmd_o.op = DP_MIN_DIV;
      ST_MIN_SPLIT:  cmd_o.op = DP_MIN_SPLIT;
      ST_WDAY_DIV:   cmd_o.op = DP_WDAY_DIV;
      ST_WDAY_SPLIT: cmd_o.op = DP_WDAY_SPLIT;
      ST_YEAR:       cmd_o.op = DP_YEAR_STEP;
      ST_MONTH:      cmd_o.op = DP_MONTH_STEP;
      ST_DONE:       if (sts_i.out_free) cmd_o.op = DP_FINISH;
      default:       cmd_o.op = DP_NOP;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/esc_dpath.sv @@
// datapath of the epoch to calendar block: reciprocal multiply division by constants,
// year and month walk, output register; depends on esc_pkg and the assert header
`default_nettype none

`include "epoch_seconds_to_calendar_core_assert.svh"

module esc_dpath
  import esc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esc_cmd_t               cmd_i,
  input  logic [31:0]            secs_i,
  input  logic                   out_ready_i,
  output esc_sts_t               sts_o,
  output logic                   out_valid_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  // working registers
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] days_q, days_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [2:0]  wday_q, wday_d;
  logic [11:0] year_q, year_d;
  logic [1:0]  y4_q, y4_d;
  logic [6:0]  y100_q, y100_d;
  logic [8:0]  y400_q, y400_d;
  logic [3:0]  mon_q, mon_d;

  // output register
  logic                   oval_q, oval_d;
  logic [OUT_TDATA_W-1:0] odata_q, odata_d;

  logic       leap;
  logic [8:0] year_len;
  logic [8:0] next_first;
  logic [8:0] cur_first;
  logic [4:0] dom;
  logic [3:0] month;

  // leap rule and month bounds
  assign leap       = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
  assign year_len   = leap ? 9'd366 : 9'd365;
  assign next_first = month_first(mon_q + 4'd1, leap);
  assign cur_first  = month_first(mon_q, leap);
  assign dom        = 5'(rem_q[8:0] - cur_first) + 5'd1;
  assign month      = mon_q + 4'd1;

  assign sts_o.year_fit   = (rem_q >= {23'd0, year_len});
  assign sts_o.month_more = (mon_q < LAST_MONTH_IDX) && (rem_q >= {23'd0, next_first});
  assign sts_o.out_free   = !oval_q || out_ready_i;

  // next values per operation
  always_comb begin
    rem_d    = rem_q;
    quo_d    = quo_q;
    days_d   = days_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    wday_d   = wday_q;
    year_d   = year_q;
    y4_d     = y4_q;
    y100_d   = y100_q;
    y400_d   = y400_q;
    mon_d    = mon_q;
    odata_d  = odata_q;
    oval_d   = oval_q && !out_ready_i;
    case (cmd_i.op)
      DP_LOAD: begin
        rem_d = secs_i;
      end
      // days = (secs >> 7) / 675, a 25 x 26 bit product
      DP_DAY_DIV: begin
        quo_d = 16'(({26'd0, rem_q[31:7]} * {25'd0, DAY_RECIP}) >> DAY_RECIP_SH);
      end
      DP_DAY_SPLIT: begin
        days_d = quo_q;
        rem_d  = rem_q - {16'd0, quo_q} * SECS_PER_DAY;
      end
      // hour = time of day / 3600, a 17 x 18 bit product
      DP_HOUR_DIV: begin
        quo_d = 16'(({18'd0, rem_q[16:0]} * {17'd0, HOUR_RECIP}) >> HOUR_RECIP_SH);
      end
      DP_HOUR_SPLIT: begin
        hour_d = quo_q[4:0];
        rem_d  = rem_q - {27'd0, quo_q[4:0]} * SECS_PER_HOUR;
      end
      // minute = seconds of the hour / 60, a 12 x 13 bit product
      DP_MIN_DIV: begin
        quo_d = 16'(({13'd0, rem_q[11:0]} * {12'd0, MIN_RECIP}) >> MIN_RECIP_SH);
      end
      DP_MIN_SPLIT: begin
        minute_d = quo_q[5:0];
        second_d = 6'(rem_q - {26'd0, quo_q[5:0]} * SECS_PER_MIN);
        rem_d    = {16'd0, days_q} + EPOCH_WEEKDAY;
      end
      // weeks = (days + 4) / 7, a 16 x 17 bit product
      DP_WDAY_DIV: begin
        quo_d = 16'(({17'd0, rem_q[15:0]} * {16'd0, WDAY_RECIP}) >> WDAY_RECIP_SH);
      end
      DP_WDAY_SPLIT: begin
        wday_d = 3'(rem_q - {16'd0, quo_q} * DAYS_PER_WEEK);
        rem_d  = {16'd0, days_q};
        year_d = EPOCH_YEAR;
        y4_d   = EPOCH_MOD4;
        y100_d = EPOCH_MOD100;
        y400_d = EPOCH_MOD400;
        mon_d  = '0;
      end
      DP_YEAR_STEP: begin
        if (sts_o.year_fit) begin
          rem_d  = rem_q - {23'd0, year_len};
          year_d = year_q + 12'd1;
          y4_d   = y4_q + 2'd1;
          y100_d = (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
          y400_d = (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
        end
      end
      DP_MONTH_STEP: begin
        if (sts_o.month_more) mon_d = mon_q + 4'd1;
      end
      DP_FINISH: begin
        oval_d  = 1'b1;
        odata_d = {7'd0, wday_q, second_q, minute_q, hour_q, dom, month, year_q};
      end
      default: begin
        rem_d = rem_q;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    days_q   <= days_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    wday_q   <= wday_d;
    year_q   <= year_d;
    y4_q     <= y4_d;
    y100_q   <= y100_d;
    y400_q   <= y400_d;
    mon_q    <= mon_d;
    odata_q  <= odata_d;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else begin
      oval_q <= oval_d;
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

  // a result is only written into a free output register
  `ESC_ASSERT_IMP(a_finish_free, clk_i, rst_ni, cmd_i.op == DP_FINISH, sts_o.out_free)
  // a held result has sane month, day and hour fields
  `ESC_ASSERT_IMP(a_out_range, clk_i, rst_ni, oval_q,
    (odata_q[15:12] != 4'd0) && (odata_q[15:12] <= 4'd12) &&
    (odata_q[20:16] != 5'd0) && (odata_q[25:21] <= 5'd23))
  // a whole-year subtraction advances the year by one
  `ESC_ASSERT_NXT(a_year_adv, clk_i, rst_ni,
    (cmd_i.op == DP_YEAR_STEP) && sts_o.year_fit, year_q == $past(year_q) + 12'd1)

endmodule

`default_nettype wire
